>>> design/assert_macros.svh
// Assertion macros for the design. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/fndt_pkg.sv
package fndt_pkg;

	localparam int TABLE_SIZE  = 16;
	localparam int NAME_BYTES  = 8;
	localparam int SECTOR_BITS = 16;

	localparam int IDX_W    = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int NAME_W   = NAME_BYTES * 8;
	localparam int SECTOR_W = SECTOR_BITS;

	// Request kinds; the fourth code is not a request and changes nothing.
	typedef enum logic [1:0] {
		REQ_FIND   = 2'd0,
		REQ_ADD    = 2'd1,
		REQ_REMOVE = 2'd2
	} req_kind_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] file_name;
		logic [15:0] header_sector;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [3:0]  entry_index;
		logic [15:0] found_sector;
	} rsp_t;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [NAME_W-1:0]   name;
		logic [SECTOR_W-1:0] sector;
	} entry_t;

	typedef struct packed {
		logic   rd_en;
		idx_t   rd_addr;
		logic   wr_en;
		logic   set_valid;
		logic   clr_valid;
		idx_t   wr_addr;
		entry_t wr_data;
	} tbl_cmd_t;

endpackage

>>> design/fndt_if.sv
interface fndt_req_if;
	logic            valid;
	logic            ready;
	fndt_pkg::req_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fndt_rsp_if;
	logic            valid;
	logic            ready;
	fndt_pkg::rsp_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/fndt_table.sv
module fndt_table (
	input  logic               clk,
	input  logic               arst_n,
	input  fndt_pkg::tbl_cmd_t cmd,
	output fndt_pkg::entry_t   rd_data,
	output logic               rd_valid
);
	import fndt_pkg::*;

	entry_t                mem [TABLE_SIZE];
	entry_t                rd_data_q;
	logic [TABLE_SIZE-1:0] valid_q;
	logic                  rd_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[cmd.rd_addr];
		end
	end

	// Valid marks live in flops so that reset empties the table at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.set_valid) begin
				valid_q[cmd.wr_addr] <= 1'b1;
			end else if (cmd.clr_valid) begin
				valid_q[cmd.wr_addr] <= 1'b0;
			end
			if (cmd.rd_en) begin
				rd_valid_q <= valid_q[cmd.rd_addr];
			end
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule

>>> design/file_name_directory_table_unit.sv
// A request is taken only in idle; the scan then reads every entry in turn through
// the single read port of the table memory, then a done state writes back and
// loads the response. No new request is taken until that write-back is done.
// A new request is taken while the previous response still waits in its output register.
// Reset clears all valid marks at once (the table is empty); no clearing pass is needed.
`include "assert_macros.svh"

module file_name_directory_table_unit (
	input  logic       clk,
	input  logic       arst_n,
	fndt_req_if.sink   req,
	fndt_rsp_if.source rsp
);
	import fndt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [1:0]          req_q;
	logic [NAME_W-1:0]   name_q;
	logic [SECTOR_W-1:0] sector_q;
	idx_t                scan_idx_q;
	logic                hit_q;
	idx_t                hit_idx_q;
	logic [SECTOR_W-1:0] hit_sector_q;
	logic                free_q;
	idx_t                free_idx_q;
	logic                out_valid_q;
	rsp_t                rsp_q;

	tbl_cmd_t            cmd;
	entry_t              rd_data;
	logic                rd_valid;

	logic                in_xfer;
	logic                scan_last;
	logic                entry_match;
	logic                done_go;
	logic                add_ok;
	logic                res_ok;
	idx_t                res_idx;
	logic [SECTOR_W-1:0] res_sector;
	logic                rsp_blank;

	fndt_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd_data  (rd_data),
		.rd_valid (rd_valid)
	);

	assign req.ready   = (state_q == ST_IDLE);
	assign in_xfer     = req.valid && req.ready;
	assign scan_last   = (scan_idx_q == IDX_W'(TABLE_SIZE - 1));
	assign entry_match = rd_valid && (rd_data.name == name_q);
	assign done_go     = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	assign add_ok      = !hit_q && free_q;

	always_comb begin
		res_ok     = 1'b0;
		res_idx    = '0;
		res_sector = '0;
		case (req_q)
			REQ_FIND: begin
				res_ok = hit_q;
				if (hit_q) begin
					res_idx    = hit_idx_q;
					res_sector = hit_sector_q;
				end
			end
			REQ_ADD: begin
				res_ok = add_ok;
				if (add_ok) begin
					res_idx = free_idx_q;
				end
			end
			REQ_REMOVE: begin
				res_ok = hit_q;
				if (hit_q) begin
					res_idx = hit_idx_q;
				end
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.rd_en       = in_xfer || ((state_q == ST_SCAN) && !scan_last);
		cmd.rd_addr     = (state_q == ST_SCAN) ? scan_idx_q + idx_t'(1) : '0;
		cmd.wr_en       = done_go && (req_q == REQ_ADD) && add_ok;
		cmd.set_valid   = cmd.wr_en;
		cmd.clr_valid   = done_go && (req_q == REQ_REMOVE) && hit_q;
		cmd.wr_addr     = (req_q == REQ_ADD) ? free_idx_q : hit_idx_q;
		cmd.wr_data     = '{name: name_q, sector: sector_q};
	end

	// Request payload and scan results; no reset needed.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q    <= req.data.req_type;
			name_q   <= req.data.file_name[NAME_W-1:0];
			sector_q <= req.data.header_sector[SECTOR_W-1:0];
		end
		if (state_q == ST_SCAN) begin
			if (entry_match && !hit_q) begin
				hit_idx_q    <= scan_idx_q;
				hit_sector_q <= rd_data.sector;
			end
			if (!rd_valid && !free_q) begin
				free_idx_q <= scan_idx_q;
			end
		end
		if (done_go) begin
			rsp_q.ok           <= res_ok;
			rsp_q.entry_index  <= 4'(res_idx);
			rsp_q.found_sector <= 16'(res_sector);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_idx_q  <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new response may load in the same cycle the old one transfers.
			if (done_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q    <= ST_SCAN;
						scan_idx_q <= '0;
						hit_q      <= 1'b0;
						free_q     <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (entry_match) begin
						hit_q <= 1'b1;
					end
					if (!rd_valid) begin
						free_q <= 1'b1;
					end
					if (scan_last) begin
						state_q <= ST_DONE;
					end else begin
						scan_idx_q <= scan_idx_q + idx_t'(1);
					end
				end
				ST_DONE: begin
					if (done_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = rsp_q;

	assign rsp_blank = (rsp_q.entry_index == 4'd0) && (rsp_q.found_sector == 16'd0);

	`ASSERT_SAME(a_rsp_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q == ST_DONE))
	`ASSERT_SAME(a_fail_is_zero, clk, arst_n, out_valid_q && !rsp_q.ok, rsp_blank)
	`ASSERT_NEXT(a_scan_ends, clk, arst_n, (state_q == ST_SCAN) && scan_last, state_q == ST_DONE)
	`ASSERT_NEXT(a_scan_starts, clk, arst_n, in_xfer, (state_q == ST_SCAN) && (scan_idx_q == '0) && !hit_q && !free_q)

endmodule
